/* rtl/lrs_pkg.sv */
// Package for the lazy range-add / range-sum segment tree.
// Holds field widths, mode codes, node classes and the sequencer state type.
// No dependencies.
package lrs_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 10;
    localparam int DATA_W     = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

    typedef enum logic [1:0] {
        CLS_OUT  = 2'd0,
        CLS_IN   = 2'd1,
        CLS_PART = 2'd2
    } cls_t;

    typedef enum logic [16:0] {
        ST_CLEAR  = 17'b00000000000000001,
        ST_IDLE   = 17'b00000000000000010,
        ST_SIMPLE = 17'b00000000000000100,
        ST_BLD_A  = 17'b00000000000001000,
        ST_BLD_B  = 17'b00000000000010000,
        ST_BLD_C  = 17'b00000000000100000,
        ST_V_RD   = 17'b00000000001000000,
        ST_V_EX   = 17'b00000000010000000,
        ST_CH_RD  = 17'b00000000100000000,
        ST_CH_WR0 = 17'b00000001000000000,
        ST_CH_WR1 = 17'b00000010000000000,
        ST_DISP   = 17'b00000100000000000,
        ST_RET    = 17'b00001000000000000,
        ST_CMB_A  = 17'b00010000000000000,
        ST_CMB_B  = 17'b00100000000000000,
        ST_CMB_C  = 17'b01000000000000000,
        ST_FIN    = 17'b10000000000000000
    } state_t;

endpackage

/* rtl/lazy_range_add_range_sum_tree.sv */
// Lazy range-add / range-sum segment tree; sequencer over two node memories.
// Load writes one leaf sum; build sums each inner node from its children and
// then clears the pending increments. Add and query visit at most four nodes
// per level, pushing pending increments down; adds re-sum partial nodes.
// One item is worked at a time; after reset both memories are swept to zero
// before the first item. Depends on lrs_pkg and lrs_mem.
module lazy_range_add_range_sum_tree #(
    parameter int LEAVES = lrs_pkg::LEAVES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[1:0], range_low[11:2], range_high[21:12], value[53:22], zero pad
    input  logic [lrs_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // range_sum[31:0]
    output logic [lrs_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int LOG   = $clog2(LEAVES);
    localparam int AW    = LOG + 1;
    localparam int DEPTH = 2 * LEAVES;
    localparam int DW    = (LOG + 1 > 1) ? $clog2(LOG + 1) : 1;
    localparam int CW    = ((LOG > lrs_pkg::IDX_W) ? LOG : lrs_pkg::IDX_W) + 1;
    localparam int XW    = lrs_pkg::DATA_W;

    lrs_pkg::state_t state_reg, state_next;
    lrs_pkg::cls_t   cls_reg, cls_next;

    logic [AW-1:0]                   k_reg, k_next;
    logic [DW-1:0]                   depth_reg, depth_next;
    logic [AW:0]                     cnt_reg, cnt_next;
    logic                            clr_all_reg, clr_all_next;
    logic [lrs_pkg::MODE_W-1:0]      mode_reg, mode_next;
    logic [lrs_pkg::IDX_W-1:0]       a_reg, a_next, b_reg, b_next;
    logic [XW-1:0]                   val_reg, val_next;
    logic [XW-1:0]                   delta_reg, delta_next;
    logic [XW-1:0]                   acc_reg, acc_next;
    logic [XW-1:0]                   tmp_reg, tmp_next;
    logic                            out_valid_reg, out_valid_next;
    logic [XW-1:0]                   out_data_reg, out_data_next;

    logic          sum_we, pend_we;
    logic [AW-1:0] sum_waddr, pend_waddr, sum_raddr, pend_raddr;
    logic [XW-1:0] sum_wdata, pend_wdata, sum_rdata, pend_rdata;

    lrs_mem #(.DEPTH(DEPTH), .AW(AW), .DW(XW)) u_sum (
        .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .raddr(sum_raddr), .rdata(sum_rdata)
    );

    lrs_mem #(.DEPTH(DEPTH), .AW(AW), .DW(XW)) u_pend (
        .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
        .raddr(pend_raddr), .rdata(pend_rdata)
    );

    // Geometry of the current node, derived from its index and depth.
    logic [DW-1:0]  sh;
    logic [AW-1:0]  off;
    logic [AW-1:0]  off_sh;
    logic [AW-1:0]  span;
    logic [LOG-1:0] lo, hi;
    logic [CW-1:0]  lo_x, hi_x, a_x, b_x;
    logic           outside, covered, leaf, is_add, is_query;
    logic [XW-1:0]  delta, sum_new;
    logic [AW-1:0]  kl, kr;

    always_comb
    begin
        sh      = DW'(LOG) - depth_reg;
        off     = k_reg & ~(AW'(1) << depth_reg);
        off_sh  = off << sh;
        span    = (AW'(1) << sh) - AW'(1);
        lo      = off_sh[LOG-1:0];
        hi      = lo | span[LOG-1:0];
        lo_x    = CW'(lo);
        hi_x    = CW'(hi);
        a_x     = CW'(a_reg);
        b_x     = CW'(b_reg);
        outside = (a_x > hi_x) || (b_x < lo_x);
        covered = (lo_x >= a_x) && (hi_x <= b_x);
        leaf    = (depth_reg == DW'(LOG));
        is_add  = (mode_reg == lrs_pkg::MODE_ADD);
        is_query = (mode_reg == lrs_pkg::MODE_QUERY);
        delta   = pend_rdata + ((covered && is_add) ? val_reg : '0);
        sum_new = sum_rdata + (delta << sh);
        kl      = {k_reg[AW-2:0], 1'b0};
        kr      = {k_reg[AW-2:0], 1'b1};
    end

    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        k_next         = k_reg;
        depth_next     = depth_reg;
        cnt_next       = cnt_reg;
        clr_all_next   = clr_all_reg;
        mode_next      = mode_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        val_next       = val_reg;
        delta_next     = delta_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        sum_we     = 1'b0;
        sum_waddr  = k_reg;
        sum_wdata  = sum_new;
        sum_raddr  = k_reg;
        pend_we    = 1'b0;
        pend_waddr = k_reg;
        pend_wdata = '0;
        pend_raddr = k_reg;

        unique case (state_reg)
            lrs_pkg::ST_CLEAR:
            begin
                sum_we     = clr_all_reg;
                sum_waddr  = cnt_reg[AW-1:0];
                sum_wdata  = '0;
                pend_we    = 1'b1;
                pend_waddr = cnt_reg[AW-1:0];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            lrs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next = s_tdata[1:0];
                    a_next    = s_tdata[11:2];
                    b_next    = s_tdata[21:12];
                    val_next  = s_tdata[53:22];
                    acc_next  = '0;
                    k_next    = AW'(1);
                    depth_next = '0;
                    priority if (s_tdata[1:0] == lrs_pkg::MODE_BUILD)
                    begin
                        k_next     = AW'(LEAVES - 1);
                        state_next = lrs_pkg::ST_BLD_A;
                    end
                    else if (s_tdata[1:0] == lrs_pkg::MODE_LOAD)
                    begin
                        state_next = lrs_pkg::ST_SIMPLE;
                    end
                    else if (s_tdata[11:2] > s_tdata[21:12])
                    begin
                        // Empty range: an add does nothing, a query answers zero.
                        state_next = (s_tdata[1:0] == lrs_pkg::MODE_QUERY) ?
                                     lrs_pkg::ST_FIN : lrs_pkg::ST_SIMPLE;
                    end
                    else
                    begin
                        state_next = lrs_pkg::ST_V_RD;
                    end
                end
            end
            lrs_pkg::ST_SIMPLE:
            begin
                sum_we     = (mode_reg == lrs_pkg::MODE_LOAD) && (a_x < CW'(LEAVES));
                sum_waddr  = AW'(LEAVES) + AW'(a_reg);
                sum_wdata  = val_reg;
                state_next = lrs_pkg::ST_IDLE;
            end
            lrs_pkg::ST_BLD_A:
            begin
                sum_raddr  = kl;
                state_next = lrs_pkg::ST_BLD_B;
            end
            lrs_pkg::ST_BLD_B:
            begin
                sum_raddr  = kr;
                tmp_next   = sum_rdata;
                state_next = lrs_pkg::ST_BLD_C;
            end
            lrs_pkg::ST_BLD_C:
            begin
                sum_we    = 1'b1;
                sum_wdata = tmp_reg + sum_rdata;
                k_next    = k_reg - 1'b1;
                if (k_reg == AW'(1))
                begin
                    // Pending increments are cleared by a sweep after the sums.
                    cnt_next     = '0;
                    clr_all_next = 1'b0;
                    state_next   = lrs_pkg::ST_CLEAR;
                end
                else
                begin
                    state_next = lrs_pkg::ST_BLD_A;
                end
            end
            lrs_pkg::ST_V_RD:
            begin
                state_next = lrs_pkg::ST_V_EX;
            end
            lrs_pkg::ST_V_EX:
            begin
                // Push the pending increment (plus the new one if the node is
                // covered by an add) into this node's sum.
                sum_we     = 1'b1;
                pend_we    = 1'b1;
                delta_next = delta;
                if (is_query && covered)
                begin
                    acc_next = acc_reg + sum_new;
                end
                cls_next = outside ? lrs_pkg::CLS_OUT :
                           (covered ? lrs_pkg::CLS_IN : lrs_pkg::CLS_PART);
                state_next = (!leaf && delta != '0) ? lrs_pkg::ST_CH_RD :
                                                      lrs_pkg::ST_DISP;
            end
            lrs_pkg::ST_CH_RD:
            begin
                pend_raddr = kl;
                state_next = lrs_pkg::ST_CH_WR0;
            end
            lrs_pkg::ST_CH_WR0:
            begin
                pend_raddr = kr;
                pend_we    = 1'b1;
                pend_waddr = kl;
                pend_wdata = pend_rdata + delta_reg;
                state_next = lrs_pkg::ST_CH_WR1;
            end
            lrs_pkg::ST_CH_WR1:
            begin
                pend_we    = 1'b1;
                pend_waddr = kr;
                pend_wdata = pend_rdata + delta_reg;
                state_next = lrs_pkg::ST_DISP;
            end
            lrs_pkg::ST_DISP:
            begin
                if (cls_reg == lrs_pkg::CLS_PART)
                begin
                    k_next     = kl;
                    depth_next = depth_reg + 1'b1;
                    state_next = lrs_pkg::ST_V_RD;
                end
                else
                begin
                    state_next = lrs_pkg::ST_RET;
                end
            end
            lrs_pkg::ST_RET:
            begin
                priority if (k_reg == AW'(1))
                begin
                    state_next = is_query ? lrs_pkg::ST_FIN : lrs_pkg::ST_IDLE;
                end
                else if (!k_reg[0])
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = lrs_pkg::ST_V_RD;
                end
                else
                begin
                    // Both children done: an add refreshes the parent's sum.
                    k_next     = k_reg >> 1;
                    depth_next = depth_reg - 1'b1;
                    state_next = is_add ? lrs_pkg::ST_CMB_A : lrs_pkg::ST_RET;
                end
            end
            lrs_pkg::ST_CMB_A:
            begin
                sum_raddr  = kl;
                state_next = lrs_pkg::ST_CMB_B;
            end
            lrs_pkg::ST_CMB_B:
            begin
                sum_raddr  = kr;
                tmp_next   = sum_rdata;
                state_next = lrs_pkg::ST_CMB_C;
            end
            lrs_pkg::ST_CMB_C:
            begin
                sum_we     = 1'b1;
                sum_wdata  = tmp_reg + sum_rdata;
                state_next = lrs_pkg::ST_RET;
            end
            lrs_pkg::ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = lrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrs_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            clr_all_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_all_reg   <= clr_all_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg      <= cls_next;
        k_reg        <= k_next;
        depth_reg    <= depth_next;
        mode_reg     <= mode_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        val_reg      <= val_next;
        delta_reg    <= delta_next;
        acc_reg      <= acc_next;
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == lrs_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/lrs_mem.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the node sums and the pending increments. No dependencies.
module lrs_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/lrs_checker.sv */
// Port-level checker for the segment tree, bound to the top level.
// Depends on lrs_pkg.
module lrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lrs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lrs_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one item is worked at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // A result appears only as the sequencer finishes an item.
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while idle");

    // Load, build and add produce no result.
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[1:0] != lrs_pkg::MODE_QUERY
        |=> !$rose(m_tvalid))
        else $error("result from a non-query item");

endmodule

bind lazy_range_add_range_sum_tree lrs_checker u_lrs_checker (
    .clk(clk), .rst_n(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
